// ===== rtl/vwd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vwd_pkg - shared types and constants of the vertex weld block
// Register widths, reset values, command codes and the status word of the
// distance unit.
// ----------------------------------------------------------------------------
package vwd_pkg;

	localparam int TOL_W = 24;
	localparam logic [TOL_W-1:0] TOL_RESET = 24'd655;
	localparam int IDX_W = 8;

	localparam logic CMD_SUBMIT = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct packed {
		logic vld;
		logic hit;
	} dist_stat_t;

endpackage
`default_nettype wire

// ===== rtl/vwd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vwd_ram - simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module vwd_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/vwd_dist.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vwd_dist - L1 distance compare unit
// Register the absolute coordinate differences, then sum and compare.
// ----------------------------------------------------------------------------
module vwd_dist #(
	parameter int COORD_BITS = 24,
	parameter int AW         = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             flush,
	input  wire logic                             in_vld,
	input  wire logic [AW-1:0]                    in_idx,
	input  wire logic [3*COORD_BITS-1:0]          point,
	input  wire logic [3*COORD_BITS-1:0]          entry,
	input  wire logic [vwd_pkg::TOL_W-1:0]        tol,
	output vwd_pkg::dist_stat_t                   stat,
	output logic      [AW-1:0]                    out_idx
);
	import vwd_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int DW = (CB + 2 > TOL_W) ? CB + 2 : TOL_W;

	logic [CB-1:0] ax_s1, ay_s1, az_s1;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	logic [DW-1:0] sum;

	function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
		logic [CB:0] d;
		d = {a[CB-1], a} - {b[CB-1], b};
		return d[CB] ? CB'(-d) : d[CB-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld && !flush;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1  <= abs_diff(point[3*CB-1 -: CB], entry[3*CB-1 -: CB]);
		ay_s1  <= abs_diff(point[2*CB-1 -: CB], entry[2*CB-1 -: CB]);
		az_s1  <= abs_diff(point[CB-1:0], entry[CB-1:0]);
		idx_s1 <= in_idx;
	end

	assign sum      = DW'(ax_s1) + DW'(ay_s1) + DW'(az_s1);
	assign stat.vld = vld_s1;
	assign stat.hit = sum < DW'(tol);
	assign out_idx  = idx_s1;

endmodule
`default_nettype wire

// ===== rtl/vertex_weld_dedup_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_weld_dedup_core - mesh vertex welding with L1 tolerance
// Keeps a table of unique vertices; each submitted vertex is matched against
// the stored entries (lowest index wins) or appended under the next index if room.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | word
//  ---------+--------------------+-------------------------------------------
//  command  | start / busy       | cmd, coord_x, coord_y, coord_z
//  result   | done (1-cycle)     | vertex_index, is_duplicate, table_full
//  config   | cfg_we             | cfg_wdata (match tolerance)
//
//  A clear word answers in the cycle after acceptance. A vertex word first
//  scans the stored entries in index order, one read of the single read port
//  of the entry RAM per cycle, each read going through the compare pipeline;
//  a match at entry k ends the scan and answers with k, else the append cycle
//  and then the result cycle follow (an empty table goes straight to append).
//  For a vertex word, busy is high from acceptance until the result strobe. The
//  result strobe cannot be held off. Reset empties the table and loads the
//  tolerance with its reset value; no clearing pass.
//
module vertex_weld_dedup_core #(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS   = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          cmd,
	input  wire logic signed [COORD_BITS-1:0]  coord_x,
	input  wire logic signed [COORD_BITS-1:0]  coord_y,
	input  wire logic signed [COORD_BITS-1:0]  coord_z,
	input  wire logic                          cfg_we,
	input  wire logic [vwd_pkg::TOL_W-1:0]     cfg_wdata,
	output logic                               done,
	output logic [vwd_pkg::IDX_W-1:0]          vertex_index,
	output logic                               is_duplicate,
	output logic                               table_full
);
	import vwd_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int EW = 3 * COORD_BITS;
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_VERTICES);

	// sequencer states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_APPEND = 2'd2;

	logic [1:0]       state_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    addr_q;
	logic [EW-1:0]    pt_q;
	logic [TOL_W-1:0] tol_q;
	logic             ram_vld_q;
	logic [AW-1:0]    ram_idx_q;
	logic             done_q;
	logic [IDX_W-1:0] vidx_q;
	logic             dup_q;
	logic             full_q;

	logic             accept;
	logic             rd_en;
	logic             wr_en;
	logic             hit_now;
	logic             flush;
	logic             last_miss;
	logic [EW-1:0]    entry;
	dist_stat_t       dstat;
	logic [AW-1:0]    d_idx;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// a hit in the scan ends the item; drop whatever reads are still in flight
	assign hit_now   = (state_q == ST_SCAN) && dstat.vld && dstat.hit;
	assign flush     = hit_now;
	assign last_miss = (state_q == ST_SCAN) && dstat.vld && !dstat.hit &&
	                   ((CW'(d_idx) + CW'(1)) == count_q);

	// issue one entry read per cycle until every stored entry is on its way or a hit ends the scan
	assign rd_en = (state_q == ST_SCAN) && (addr_q < count_q) && !hit_now;
	assign wr_en = (state_q == ST_APPEND) && (count_q != COUNT_MAX);

	vwd_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_VERTICES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[AW-1:0]),
		.wdata (pt_q),
		.re    (rd_en),
		.raddr (addr_q[AW-1:0]),
		.rdata (entry)
	);

	vwd_dist #(
		.COORD_BITS (COORD_BITS),
		.AW         (AW)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.flush   (flush),
		.in_vld  (ram_vld_q),
		.in_idx  (ram_idx_q),
		.point   (pt_q),
		.entry   (entry),
		.tol     (tol_q),
		.stat    (dstat),
		.out_idx (d_idx)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			tol_q     <= TOL_RESET;
			ram_vld_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			ram_vld_q <= rd_en;
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_CLEAR) begin
							// clear: empty the table and answer without a scan
							count_q <= '0;
							done_q  <= 1'b1;
						end else if (count_q == '0) begin
							state_q <= ST_APPEND;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit_now) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (last_miss) begin
						state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (count_q != COUNT_MAX) begin
						count_q <= count_q + CW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: latched vertex, read address and result word
	always_ff @(posedge clk) begin
		ram_idx_q <= addr_q[AW-1:0];
		if (accept) begin
			pt_q   <= {coord_x, coord_y, coord_z};
			addr_q <= '0;
			vidx_q <= '0;
			dup_q  <= 1'b0;
			full_q <= 1'b0;
		end else if (rd_en) begin
			addr_q <= addr_q + CW'(1);
		end
		if (hit_now) begin
			vidx_q <= IDX_W'(d_idx);
			dup_q  <= 1'b1;
			full_q <= 1'b0;
		end else if (state_q == ST_APPEND) begin
			dup_q <= 1'b0;
			if (count_q == COUNT_MAX) begin
				vidx_q <= '0;
				full_q <= 1'b1;
			end else begin
				vidx_q <= IDX_W'(count_q);
				full_q <= 1'b0;
			end
		end
	end

	assign done         = done_q;
	assign vertex_index = vidx_q;
	assign is_duplicate = dup_q;
	assign table_full   = full_q;

endmodule
`default_nettype wire

// ===== rtl/vwd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vwd_checker - port level checks for the vertex weld block
// Watches the command and result ports; bound to the top level below.
// ----------------------------------------------------------------------------
module vwd_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic                      cmd,
	input wire logic                      done,
	input wire logic [vwd_pkg::IDX_W-1:0] vertex_index,
	input wire logic                      is_duplicate,
	input wire logic                      table_full
);
	import vwd_pkg::*;

	// clear answers next cycle with an all-zero word
	a_clear_resp: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_CLEAR |=>
			done && vertex_index == '0 && !is_duplicate && !table_full)
		else $error("clear word not answered with zero result");

	// an accepted vertex sets the block busy, with no result strobe yet
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_SUBMIT |=> busy && !done)
		else $error("vertex accepted without going busy");

	// result strobe only when returning to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// a duplicate is never reported as a table overflow
	a_dup_full: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_duplicate && table_full))
		else $error("duplicate and table full together");

	// overflow word carries index zero
	a_full_idx: assert property (@(posedge clk) disable iff (!arst_n)
		done && table_full |-> vertex_index == '0)
		else $error("table full with non-zero index");

endmodule

bind vertex_weld_dedup_core vwd_checker u_vwd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.cmd          (cmd),
	.done         (done),
	.vertex_index (vertex_index),
	.is_duplicate (is_duplicate),
	.table_full   (table_full)
);
`default_nettype wire
